FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define BDIL3_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition must never be seen outside reset
`define BDIL3_ASSERT_NEVER(label, clk, rst, cond) \
   `BDIL3_ASSERT(label, clk, rst, !(cond))

`endif

FILE: rtl/core/bdil3_pkg.sv
// shared types and constants of the 3x3 binary dilation block
`timescale 1ns / 1ps

package bdil3_pkg;

   // stream word widths
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 8;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 11;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

   // word kinds carried on tuser
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // reset frame size before clamping
   localparam int FRAME_DIM_RESET = 64;

   // one line buffer entry: horizontal 3-or of two buffered rows
   typedef struct packed {
      logic above;
      logic cur;
   } line_entry_type;

endpackage

FILE: rtl/core/binary_dilation_3x3.sv
// Usage: streaming 3x3 square binary dilation of a raster-order image.
// req channel: one word per pixel, tuser = 0 with the pixel on tdata, or
// tuser = 1 for a drain word that releases one pending mask pixel once the
// whole frame is in. rsp channel: tdata[0] = mask bit, tlast on the final
// mask pixel of the frame. csr port: index 0 = frame width, 1 = frame height,
// both clamped to 1..MAX_WIDTH / 1..MAX_HEIGHT; a write restarts the frame.
// Throughput: one word per cycle while not stalled, pixels and drains alike,
// set by the single line buffer memory with one write and one registered read
// per cycle; the read address of the next word is issued from the next-state
// counters. Each result is registered in the output or skid entry. The mask
// lags one row plus one pixel: with two or more rows the first row plus one
// pixel give no result and width + 1 drain words flush the rest of the frame;
// a one-row frame gives nothing until its width drain words.
// Stall: a two-entry output (register plus skid) keeps req_tready high while
// one result waits; req_tready drops only when both entries are full.
// Reset: synchronous; frame size returns to 64 x 64 (clamped), counters clear.
// The line buffer is not cleared; every entry is written before it is read.
`timescale 1ns / 1ps

module binary_dilation_3x3 #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // input stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bdil3_pkg::REQ_TDATA_W-1:0]      req_tdata,   // pixel[7:0]
   input  logic                                   req_tuser,   // func
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [bdil3_pkg::RSP_TDATA_W-1:0]      rsp_tdata,   // mask_bit, zero pad
   output logic                                   rsp_tlast,
   // configuration writes
   input  logic                                   csr_we,
   input  logic [bdil3_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [bdil3_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   localparam logic [WW-1:0] WIDTH_RST =
      WW'((bdil3_pkg::FRAME_DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : bdil3_pkg::FRAME_DIM_RESET);
   localparam logic [HW-1:0] HEIGHT_RST =
      HW'((bdil3_pkg::FRAME_DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                    : bdil3_pkg::FRAME_DIM_RESET);

   // frame size
   logic [WW-1:0] width_ff, width_in;
   logic [HW-1:0] height_ff, height_in;

   // raster counters and window
   logic [AW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [AW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [1:0]    window_ff, window_in;
   logic          done_ff, done_in;
   logic          tail_ff, tail_in;

   // line buffer
   bdil3_pkg::line_entry_type line_mem [MAX_WIDTH];
   bdil3_pkg::line_entry_type rd_ff;
   bdil3_pkg::line_entry_type wdata;
   logic [AW-1:0]             waddr;
   logic [AW-1:0]             raddr_in;
   logic                      mem_we;

   // output register and skid stage
   logic out_valid_ff, out_mask_ff, out_last_ff;
   logic skid_valid_ff, skid_mask_ff, skid_last_ff;

   // step signals
   logic          req_fire;
   logic          rsp_fire;
   logic          nz;
   logic          h_ge2, h_ge3;
   logic          last_col_in, last_row_in, last_out;
   logic [AW-1:0] w_last_addr;
   logic          h_or;
   logic          ge1, ge2;
   logic          fwd;
   logic          emit;
   logic          mask;
   logic [WW-1:0] width_clamp;
   logic [HW-1:0] height_clamp;
   logic          h_ge2_next;
   logic [AW-1:0] w_last_addr_next;

   assign req_fire    = req_tvalid && req_tready;
   assign rsp_fire    = out_valid_ff && rsp_tready;
   assign nz          = |req_tdata;
   assign h_ge2       = int'(height_ff) >= 2;
   assign h_ge3       = int'(height_ff) >= 3;
   assign w_last_addr = AW'(width_ff - WW'(1));
   assign last_col_in = WW'(in_col_ff) == (width_ff - WW'(1));
   assign last_row_in = HW'(in_row_ff) == (height_ff - HW'(1));
   assign last_out    = (WW'(out_col_ff) == (width_ff - WW'(1))) &&
                        (HW'(out_row_ff) == (height_ff - HW'(1)));

   // clamp incoming frame size
   always_comb begin
      if (csr_wdata == '0) begin
         width_clamp  = WW'(1);
         height_clamp = HW'(1);
      end else begin
         width_clamp  = (int'(csr_wdata) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(csr_wdata);
         height_clamp = (int'(csr_wdata) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(csr_wdata);
      end
   end

   // one word of work: column finish, mask pick and counter update
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      window_in  = window_ff;
      done_in    = done_ff;
      tail_in    = tail_ff;
      mem_we     = 1'b0;
      waddr      = w_last_addr;
      h_or       = 1'b0;
      ge1        = 1'b0;
      ge2        = 1'b0;
      fwd        = 1'b0;
      emit       = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            bdil3_pkg::CFG_FRAME_WIDTH:  width_in  = width_clamp;
            bdil3_pkg::CFG_FRAME_HEIGHT: height_in = height_clamp;
            default: ;
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         window_in  = '0;
         done_in    = 1'b0;
         tail_in    = 1'b0;
      end else if (req_fire) begin
         if ((req_tuser == bdil3_pkg::FUNC_PIXEL) && !done_ff) begin
            // pixel: finish the column behind it
            if (in_col_ff != '0) begin
               mem_we    = 1'b1;
               waddr     = in_col_ff - AW'(1);
               h_or      = window_ff[1] | window_ff[0] | nz;
               ge1       = in_row_ff != '0;
               ge2       = int'(in_row_ff) >= 2;
               window_in = {window_ff[0], nz};
            end else begin
               mem_we    = in_row_ff != '0;
               h_or      = window_ff[1] | window_ff[0];
               ge1       = int'(in_row_ff) >= 2;
               ge2       = int'(in_row_ff) >= 3;
               window_in = {1'b0, nz};
            end
            emit = mem_we && ge1;
            if (last_col_in) begin
               in_col_in = '0;
               if (last_row_in) begin
                  done_in = 1'b1;
                  tail_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + RW'(1);
               end
            end else begin
               in_col_in = in_col_ff + AW'(1);
            end
         end else if ((req_tuser == bdil3_pkg::FUNC_DRAIN) && done_ff) begin
            // drain: first one finishes the last column of the last row
            emit    = 1'b1;
            tail_in = 1'b0;
            if (tail_ff) begin
               mem_we = 1'b1;
               h_or   = window_ff[1] | window_ff[0];
               if (h_ge2) begin
                  ge1 = 1'b1;
                  ge2 = h_ge3;
               end else begin
                  fwd = w_last_addr == out_col_ff;
               end
            end
         end
         // advance the output position, restart after the last one
         if (emit) begin
            if (last_out) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
               window_in  = '0;
               done_in    = 1'b0;
               tail_in    = 1'b0;
            end else if (WW'(out_col_ff) == (width_ff - WW'(1))) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + AW'(1);
            end
         end
      end
   end

   // mask value from the window and the buffered rows
   always_comb begin
      if (mem_we && ge1) begin
         mask = h_or | rd_ff.cur | (ge2 & rd_ff.above);
      end else begin
         mask = (fwd ? h_or : rd_ff.cur) | (h_ge2 & rd_ff.above);
      end
   end

   assign wdata.above = rd_ff.cur;
   assign wdata.cur   = h_or;

   // read address for the next word, from next-state counters
   assign h_ge2_next       = int'(height_in) >= 2;
   assign w_last_addr_next = AW'(width_in - WW'(1));
   always_comb begin
      if (!done_in) begin
         raddr_in = (in_col_in != '0) ? (in_col_in - AW'(1)) : w_last_addr_next;
      end else if (tail_in && h_ge2_next) begin
         raddr_in = w_last_addr_next;
      end else begin
         raddr_in = out_col_in;
      end
   end

   // line buffer with write-through bypass on the registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[waddr] <= wdata;
      end
      if (mem_we && (waddr == raddr_in)) begin
         rd_ff <= wdata;
      end else begin
         rd_ff <= line_mem[raddr_in];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_RST;
         height_ff  <= HEIGHT_RST;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         window_ff  <= '0;
         done_ff    <= 1'b0;
         tail_ff    <= 1'b0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         window_ff  <= window_in;
         done_ff    <= done_in;
         tail_ff    <= tail_in;
      end
   end

   // output register and skid valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_fire) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff || rsp_fire) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_ff <= 1'b0;
      end
   end

   // output and skid payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_mask_ff <= skid_mask_ff;
            out_last_ff <= skid_last_ff;
         end
      end else if (emit) begin
         if (!out_valid_ff || rsp_fire) begin
            out_mask_ff <= mask;
            out_last_ff <= last_out;
         end else begin
            skid_mask_ff <= mask;
            skid_last_ff <= last_out;
         end
      end
   end

   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(bdil3_pkg::RSP_TDATA_W - 1){1'b0}}, out_mask_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

FILE: rtl/core/bdil3_checker.sv
// port-level checker of the 3x3 binary dilation block and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdil3_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bdil3_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast
);

   // input side closes only when a result waits and the receiver stalls
   `BDIL3_ASSERT(a_ready_fall, clock, reset, $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))

   // a closed input side means results are buffered
   `BDIL3_ASSERT_NEVER(a_ready_empty, clock, reset, !req_tready && !rsp_tvalid)

   // a stalled result stays offered
   `BDIL3_ASSERT(a_valid_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // a stalled result keeps its word
   `BDIL3_ASSERT(a_word_hold, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))

endmodule

bind binary_dilation_3x3 bdil3_checker u_bdil3_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

FILE: dv/testbench.sv
// self-checking testbench for the streaming 3x3 binary dilation block
`timescale 1ns / 1ps

module testbench;

   localparam int MAX_DIM        = 1024;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 640;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bdil3_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;    // pixel[7:0]
   logic                              req_tuser  = bdil3_pkg::FUNC_PIXEL;  // func
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bdil3_pkg::RSP_TDATA_W-1:0] rsp_tdata;          // mask_bit, zero pad
   logic                              rsp_tlast;
   logic                              csr_we     = 1'b0;
   logic [bdil3_pkg::CSR_INDEX_W-1:0] csr_index  = bdil3_pkg::CFG_FRAME_WIDTH;
   logic [bdil3_pkg::CSR_DATA_W-1:0]  csr_wdata  = '0;

   binary_dilation_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected mask words, oldest first
   typedef struct packed {
      logic mask_bit;
      logic frame_last;
   } mask_word_type;

   mask_word_type  pending_masks[$];
   mask_word_type  head_mask;

   // dilation state: horizontal 3-or of the two buffered rows
   bit          above_or [MAX_DIM];
   bit          cur_or [MAX_DIM];
   bit [1:0]    win_nz;
   int unsigned col_in, row_in, mask_pos;
   int unsigned frame_w, frame_h;

   int unsigned useful_words;
   int          error_count  = 0;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   int          stall_left   = 0;
   int          quiet_cycles = 0;

   function automatic int unsigned clamp_dim(input logic [bdil3_pkg::CSR_DATA_W-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return 32'(v);
   endfunction

   function automatic void restart_frame();
      win_nz   = 2'b00;
      col_in   = 0;
      row_in   = 0;
      mask_pos = 0;
   endfunction

   // register write: clamp and restart the frame
   function automatic void apply_reg(input logic [bdil3_pkg::CSR_INDEX_W-1:0] idx,
                                     input logic [bdil3_pkg::CSR_DATA_W-1:0] val);
      if (idx == bdil3_pkg::CFG_FRAME_WIDTH) frame_w = clamp_dim(val);
      else frame_h = clamp_dim(val);
      restart_frame();
   endfunction

   function automatic void push_mask(input bit m);
      mask_word_type w;
      w.mask_bit   = m;
      w.frame_last = (mask_pos + 1 >= frame_w * frame_h);
      pending_masks.push_back(w);
      if (w.frame_last) restart_frame();
      else mask_pos++;
   endfunction

   // finish the horizontal or of one column; emits the row above once it exists
   function automatic bit close_column(input int unsigned hrow, input int unsigned col,
                                       input bit h);
      bit m;
      if (hrow >= 1) begin
         m = h | cur_or[col];
         if (hrow >= 2) m = m | above_or[col];
         above_or[col] = cur_or[col];
         cur_or[col]   = h;
         push_mask(m);
         return 1'b1;
      end
      cur_or[col] = h;
      return 1'b0;
   endfunction

   // predict the effect of one accepted input word
   function automatic void dilate_word(input logic func, input logic [7:0] pix);
      bit          nz;
      bit          all_in;
      bit          m;
      int unsigned r, c, base, co;
      nz     = (pix != 8'h00);
      all_in = (row_in >= frame_h);
      if (func == bdil3_pkg::FUNC_PIXEL) begin
         if (all_in) return;
         useful_words++;
         r = row_in;
         c = col_in;
         if (c >= 1) begin
            void'(close_column(r, c - 1, win_nz[1] | win_nz[0] | nz));
            win_nz = {win_nz[0], nz};
         end else begin
            if (r >= 1) void'(close_column(r - 1, frame_w - 1, win_nz[1] | win_nz[0]));
            win_nz = {1'b0, nz};
         end
         col_in = c + 1;
         if (col_in >= frame_w) begin
            col_in = 0;
            row_in = r + 1;
         end
      end else begin
         if (!all_in) return;
         useful_words++;
         base = (frame_h >= 2) ? frame_w * frame_h - frame_w - 1 : 0;
         if (mask_pos == base) begin
            if (close_column(frame_h - 1, frame_w - 1, win_nz[1] | win_nz[0])) return;
         end
         co = mask_pos % frame_w;
         m  = cur_or[co];
         if (frame_h >= 2) m = m | above_or[co];
         push_mask(m);
      end
   endfunction

   // send one word, with an optional idle burst ahead of it
   task automatic send_word(input logic func, input logic [7:0] pix);
      int gap;
      gap = 0;
      if (req_idle_pct > 0 && $urandom_range(0, 99) < req_idle_pct)
         gap = $urandom_range(1, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
      dilate_word(func, pix);
   endtask

   // let all expected masks arrive, then allow the pipeline to empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_masks.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // configuration writes on consecutive edges
   task automatic write_regs(input bit do_width, input bit do_height,
                             input int wv, input int hv);
      if (do_width) begin
         csr_we    <= 1'b1;
         csr_index <= bdil3_pkg::CFG_FRAME_WIDTH;
         csr_wdata <= wv[bdil3_pkg::CSR_DATA_W-1:0];
         @(posedge clock);
         apply_reg(bdil3_pkg::CFG_FRAME_WIDTH, wv[bdil3_pkg::CSR_DATA_W-1:0]);
      end
      if (do_height) begin
         csr_we    <= 1'b1;
         csr_index <= bdil3_pkg::CFG_FRAME_HEIGHT;
         csr_wdata <= hv[bdil3_pkg::CSR_DATA_W-1:0];
         @(posedge clock);
         apply_reg(bdil3_pkg::CFG_FRAME_HEIGHT, hv[bdil3_pkg::CSR_DATA_W-1:0]);
      end
      csr_we <= 1'b0;
   endtask

   // one whole frame at the current size, then the drain words that flush it
   task automatic send_frame(input int density, input bit noisy);
      int unsigned npix;
      npix = frame_w * frame_h;
      for (int unsigned i = 0; i < npix; i++) begin
         // drain while the frame is still open is dropped
         if (noisy && $urandom_range(0, 99) < 3)
            send_word(bdil3_pkg::FUNC_DRAIN, 8'($urandom));
         send_word(bdil3_pkg::FUNC_PIXEL,
                   ($urandom_range(0, 99) < density) ? 8'($urandom_range(1, 255)) : 8'h00);
      end
      // pixel once the frame is complete is dropped
      if (noisy && $urandom_range(0, 99) < 30) send_word(bdil3_pkg::FUNC_PIXEL, 8'($urandom));
      while (row_in >= frame_h) send_word(bdil3_pkg::FUNC_DRAIN, 8'($urandom));
      if (noisy && $urandom_range(0, 99) < 10) send_word(bdil3_pkg::FUNC_DRAIN, 8'($urandom));
   endtask

   // reset size: a stray drain and the first pixels give nothing
   task automatic test_reset_size();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_word(bdil3_pkg::FUNC_DRAIN, 8'hFF);
      for (int i = 0; i < 4; i++) send_word(bdil3_pkg::FUNC_PIXEL, 8'(i * 85));
      settle();
   endtask

   // tiny frames: single pixel, lone corners, single column, single row
   task automatic test_small_frames();
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      // zero sizes clamp to one pixel
      write_regs(1'b1, 1'b1, 0, 0);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'hFF);
      send_word(bdil3_pkg::FUNC_DRAIN, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_DRAIN, 8'hFF);
      send_word(bdil3_pkg::FUNC_DRAIN, 8'h5A);
      settle();

      write_regs(1'b1, 1'b1, 3, 3);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h80);
      for (int i = 0; i < 7; i++) send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h01);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'hFF);
      while (row_in >= frame_h) send_word(bdil3_pkg::FUNC_DRAIN, 8'h00);
      settle();

      // one column: nothing may leak in from the sides
      write_regs(1'b1, 1'b1, 1, 3);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h7F);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      while (row_in >= frame_h) send_word(bdil3_pkg::FUNC_DRAIN, 8'h00);
      settle();

      // one row: drains only
      write_regs(1'b1, 1'b1, 5, 1);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h40);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      send_word(bdil3_pkg::FUNC_PIXEL, 8'h00);
      while (row_in >= frame_h) send_word(bdil3_pkg::FUNC_DRAIN, 8'hAA);
      settle();
   endtask

   // a register write in the middle of a frame starts it over
   task automatic test_restart_mid_frame();
      req_idle_pct = 10;
      rsp_idle_pct = 30;
      write_regs(1'b1, 1'b1, 4, 3);
      for (int i = 0; i < 6; i++)
         send_word(bdil3_pkg::FUNC_PIXEL, (i == 2) ? 8'h10 : 8'h00);
      settle();
      write_regs(1'b0, 1'b1, 0, 2);
      send_frame(30, 1'b0);
      settle();
   endtask

   // largest sizes, partial frames cut short by the next register write
   task automatic test_size_extremes();
      req_idle_pct = 5;
      rsp_idle_pct = 5;
      write_regs(1'b1, 1'b1, 2047, 2047);
      for (int i = 0; i < 60; i++) send_word(bdil3_pkg::FUNC_PIXEL, 8'($urandom));
      settle();
      write_regs(1'b1, 1'b1, 1, 2047);
      for (int i = 0; i < 60; i++)
         send_word(bdil3_pkg::FUNC_PIXEL,
                   ($urandom_range(0, 99) < 10) ? 8'($urandom_range(1, 255)) : 8'h00);
      settle();
      write_regs(1'b1, 1'b1, 1024, 1);
      for (int i = 0; i < 30; i++) send_word(bdil3_pkg::FUNC_PIXEL, 8'($urandom));
      settle();
      write_regs(1'b1, 1'b1, 8, 4);
   endtask

   // random small frames with random content, noise and idling
   task automatic test_random_frames();
      int wv, hv, sel;
      bit calm;
      useful_words = 0;
      while (useful_words < RANDOM_WORDS) begin
         // last stretch runs with no idling
         calm = (useful_words > RANDOM_WORDS * 85 / 100);
         if (calm) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 3))
               0: req_idle_pct = 0;
               1: req_idle_pct = 5;
               2: req_idle_pct = 20;
               default: req_idle_pct = 50;
            endcase
            case ($urandom_range(0, 3))
               0: rsp_idle_pct = 0;
               1: rsp_idle_pct = 5;
               2: rsp_idle_pct = 20;
               default: rsp_idle_pct = 50;
            endcase
         end
         if ($urandom_range(0, 99) < 70) begin
            sel = $urandom_range(0, 19);
            if (sel < 16) begin
               wv = $urandom_range(1, 8);
               hv = $urandom_range(1, 6);
            end else if (sel < 19) begin
               wv = $urandom_range(9, 40);
               hv = $urandom_range(1, 4);
            end else begin
               wv = $urandom_range(1, 3);
               hv = $urandom_range(20, 40);
            end
            settle();
            sel = $urandom_range(1, 3);
            write_regs(sel[0], sel[1], wv, hv);
         end
         case ($urandom_range(0, 4))
            0: send_frame(0, !calm);
            1: send_frame(5, !calm);
            2: send_frame(15, !calm);
            3: send_frame(40, !calm);
            default: send_frame(100, !calm);
         endcase
      end
   endtask

   // result side: random stalls and the check of each mask word
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_masks.size() == 0) begin
               $display("%0t: unexpected mask word: expected none, actual tdata %h last %b",
                        $time, rsp_tdata, rsp_tlast);
               error_count++;
            end else begin
               head_mask = pending_masks.pop_front();
               if (rsp_tdata !== bdil3_pkg::RSP_TDATA_W'(head_mask.mask_bit)) begin
                  $display("%0t: mask bit mismatch: expected tdata %h, actual %h",
                           $time, bdil3_pkg::RSP_TDATA_W'(head_mask.mask_bit), rsp_tdata);
                  error_count++;
               end
               if (rsp_tlast !== head_mask.frame_last) begin
                  $display("%0t: frame last mismatch: expected %b, actual %b",
                           $time, head_mask.frame_last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_idle_pct > 0 && $urandom_range(0, 99) < rsp_idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any word moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      frame_w = bdil3_pkg::FRAME_DIM_RESET;
      frame_h = bdil3_pkg::FRAME_DIM_RESET;
      restart_frame();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_small_frames();
      test_restart_mid_frame();
      test_size_extremes();
      test_random_frames();
      settle();

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
